// ===== design/cal_pkg.sv =====
// shared types and constants for the cursor array list
// no dependencies
`timescale 1ns / 1ps

package cal_pkg;

	localparam int DEPTH      = 1024;
	localparam int DATA_WIDTH = 64;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int MODE_W     = 4;
	localparam int STATUS_W   = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_INS_BEFORE = 4'd0,
		MODE_INS_AFTER  = 4'd1,
		MODE_DELETE     = 4'd2,
		MODE_PREV       = 4'd3,
		MODE_NEXT       = 4'd4,
		MODE_START      = 4'd5,
		MODE_END        = 4'd6,
		MODE_RD_CUR     = 4'd7,
		MODE_RD_IDX     = 4'd8,
		MODE_WR_IDX     = 4'd9
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SHIFT,
		S_PUT,
		S_FINISH
	} state_t;

endpackage

// ===== design/cal_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module cal_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/cursor_array_list.sv =====
// cursor array list over one element store; depends on cal_pkg and cal_ram
// moves, reads and indexed writes run an execute step, then a finish step that loads the output register
// an insert runs execute, shift, put and finish steps, a delete execute, shift and finish steps;
// shift moves one element per cycle through the single write port; words are taken only in idle
// a finished word waits in the output register while the next word is taken
// reset clears count, cursor and handshake state; the element store is not cleared
`timescale 1ns / 1ps

module cursor_array_list
	import cal_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [MODE_W-1:0]     mode,
	input  logic [DATA_WIDTH-1:0] data_in,
	input  logic [ADDR_W-1:0]     position,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [STATUS_W-1:0]   status,
	output logic [DATA_WIDTH-1:0] data_out,
	output logic                  moved,
	output logic [CNT_W-1:0]      count,
	output logic [ADDR_W-1:0]     cursor_pos
);

	state_t state_q, state_d;

	// accepted input word
	logic [MODE_W-1:0]     mode_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [ADDR_W-1:0]     pos_q;

	// list state
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] cur_q;

	// shift engine
	logic [CNT_W-1:0]  len_q;
	logic [ADDR_W-1:0] src_q;
	logic              up_q;
	logic              ins_q;
	logic [ADDR_W-1:0] slot_q;
	logic              rd_vld_s1;
	logic [ADDR_W-1:0] rd_addr_s1;

	// result waiting for the finish step
	status_t res_status_q;
	logic    res_moved_q;
	logic    res_rd_q;

	// output register, held while the next word runs
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [DATA_WIDTH-1:0] data_out_q;
	logic                  moved_q;
	logic [CNT_W-1:0]      count_out_q;
	logic [ADDR_W-1:0]     cur_out_q;

	// decode results
	status_t           ex_status;
	logic              ex_moved;
	logic              ex_rd;
	logic              ex_shift;
	logic              ex_ins;
	logic              ex_up;
	logic [CNT_W-1:0]  ex_len;
	logic [ADDR_W-1:0] ex_src;
	logic [ADDR_W-1:0] ex_slot;
	logic [CNT_W-1:0]  ex_count;
	logic [ADDR_W-1:0] ex_cur;
	logic              ex_we;
	logic              ex_re;
	logic [ADDR_W-1:0] ex_raddr;

	// store ports
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic                  ram_re;
	logic [ADDR_W-1:0]     ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;

	logic [CNT_W-1:0]  cur_ext;
	logic [CNT_W-1:0]  cur_inc;
	logic [CNT_W-1:0]  cnt_dec;
	logic              out_free;
	logic              shift_rd;
	logic              shift_done;

	assign cur_ext    = {1'b0, cur_q};
	assign cur_inc    = cur_ext + CNT_W'(1);
	assign cnt_dec    = count_q - CNT_W'(1);
	assign out_free   = !out_valid_q || out_ready;
	assign shift_rd   = (state_q == S_SHIFT) && (len_q != '0);
	assign shift_done = (len_q == '0) && !rd_vld_s1;

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign data_out   = data_out_q;
	assign moved      = moved_q;
	assign count      = count_out_q;
	assign cursor_pos = cur_out_q;

	// operation decode, evaluated in the execute step
	always_comb begin
		ex_status = ST_OK;
		ex_moved  = 1'b0;
		ex_rd     = 1'b0;
		ex_shift  = 1'b0;
		ex_ins    = 1'b0;
		ex_up     = 1'b1;
		ex_len    = '0;
		ex_src    = cnt_dec[ADDR_W-1:0];
		ex_slot   = '0;
		ex_count  = count_q;
		ex_cur    = cur_q;
		ex_we     = 1'b0;
		ex_re     = 1'b0;
		ex_raddr  = cur_q;
		case (mode_t'(mode_q))
			MODE_INS_BEFORE, MODE_INS_AFTER: begin
				if (count_q == CNT_W'(DEPTH)) begin
					ex_status = ST_FULL;
				end else if (count_q == '0) begin
					ex_shift = 1'b1;
					ex_ins   = 1'b1;
					ex_count = CNT_W'(1);
					ex_cur   = '0;
				end else if (mode_t'(mode_q) == MODE_INS_BEFORE) begin
					// open a slot at the cursor, cursor follows its element
					ex_shift = 1'b1;
					ex_ins   = 1'b1;
					ex_len   = count_q - cur_ext;
					ex_slot  = cur_q;
					ex_count = count_q + CNT_W'(1);
					ex_cur   = cur_inc[ADDR_W-1:0];
				end else begin
					ex_shift = 1'b1;
					ex_ins   = 1'b1;
					ex_len   = count_q - cur_inc;
					ex_slot  = cur_inc[ADDR_W-1:0];
					ex_count = count_q + CNT_W'(1);
				end
			end
			MODE_DELETE: begin
				if (count_q == '0) begin
					ex_status = ST_EMPTY;
				end else begin
					// close the gap: elements above the cursor move down
					ex_shift = 1'b1;
					ex_up    = 1'b0;
					ex_len   = cnt_dec - cur_ext;
					ex_src   = cur_inc[ADDR_W-1:0];
					ex_count = cnt_dec;
					if (cnt_dec == '0) begin
						ex_cur = '0;
					end else if (cur_ext == cnt_dec) begin
						ex_cur = cur_q - ADDR_W'(1);
					end
				end
			end
			MODE_PREV: begin
				if (count_q == '0) begin
					ex_status = ST_EMPTY;
				end else if (cur_q != '0) begin
					ex_cur   = cur_q - ADDR_W'(1);
					ex_moved = 1'b1;
				end
			end
			MODE_NEXT: begin
				if (count_q == '0) begin
					ex_status = ST_EMPTY;
				end else if (cur_inc < count_q) begin
					ex_cur   = cur_inc[ADDR_W-1:0];
					ex_moved = 1'b1;
				end
			end
			MODE_START: begin
				if (count_q == '0) begin
					ex_status = ST_EMPTY;
				end else begin
					ex_cur = '0;
				end
			end
			MODE_END: begin
				if (count_q == '0) begin
					ex_status = ST_EMPTY;
				end else begin
					ex_cur = cnt_dec[ADDR_W-1:0];
				end
			end
			MODE_RD_CUR: begin
				if (count_q == '0) begin
					ex_status = ST_EMPTY;
				end else begin
					ex_rd = 1'b1;
					ex_re = 1'b1;
				end
			end
			MODE_RD_IDX: begin
				if ({1'b0, pos_q} >= count_q) begin
					ex_status = ST_RANGE;
				end else begin
					ex_rd    = 1'b1;
					ex_re    = 1'b1;
					ex_raddr = pos_q;
				end
			end
			MODE_WR_IDX: begin
				if ({1'b0, pos_q} >= count_q) begin
					ex_status = ST_RANGE;
				end else begin
					ex_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// store port steering: execute step, shift pipeline, final word write
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = data_q;
		ram_re    = 1'b0;
		ram_raddr = ex_raddr;
		case (state_q)
			S_EXEC: begin
				ram_we    = ex_we;
				ram_re    = ex_re;
			end
			S_SHIFT: begin
				ram_re    = shift_rd;
				ram_raddr = src_q;
				ram_we    = rd_vld_s1;
				ram_waddr = up_q ? rd_addr_s1 + ADDR_W'(1) : rd_addr_s1 - ADDR_W'(1);
				ram_wdata = ram_rdata;
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = slot_q;
			end
			default: begin
			end
		endcase
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = ex_shift ? S_SHIFT : S_FINISH;
			end
			S_SHIFT: begin
				if (shift_done) begin
					state_d = ins_q ? S_PUT : S_FINISH;
				end
			end
			S_PUT: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cur_q       <= '0;
			len_q       <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= shift_rd;
			if (state_q == S_EXEC) begin
				count_q <= ex_count;
				cur_q   <= ex_cur;
				len_q   <= ex_len;
			end else if (shift_rd) begin
				len_q <= len_q - CNT_W'(1);
			end
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q <= mode;
			data_q <= data_in;
			pos_q  <= position;
		end
		if (state_q == S_EXEC) begin
			src_q        <= ex_src;
			up_q         <= ex_up;
			ins_q        <= ex_ins;
			slot_q       <= ex_slot;
			res_status_q <= ex_status;
			res_moved_q  <= ex_moved;
			res_rd_q     <= ex_rd;
		end else if (shift_rd) begin
			src_q <= up_q ? src_q - ADDR_W'(1) : src_q + ADDR_W'(1);
		end
		rd_addr_s1 <= src_q;
		if (state_q == S_FINISH && out_free) begin
			status_q    <= res_status_q;
			moved_q     <= res_moved_q;
			data_out_q  <= res_rd_q ? ram_rdata : '0;
			count_out_q <= count_q;
			cur_out_q   <= (count_q == '0) ? '0 : cur_q;
		end
	end

	cal_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

// ===== test/cursor_array_list_test.sv =====
// self-checking testbench for cursor_array_list: directed and random words
// are driven through the valid/ready ports and every reply is checked against a local model
// depends on cal_pkg and the cursor_array_list rtl
`timescale 1ns / 1ps

module cursor_array_list_test;
	import cal_pkg::*;

	// spare mode codes, which the block must ignore
	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 4'd10;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 4'd15;

	localparam int unsigned RANDOM_OPS  = 554;
	// longest insert or delete shifts the whole store, plus margin
	localparam int unsigned DRAIN_TAIL  = DEPTH + 16;
	localparam int unsigned STALL_LIMIT = 8 * (DEPTH + 16);
	localparam int unsigned MAX_REPORTS = 40;

	// one input word as queued for the driver
	typedef struct {
		logic [MODE_W-1:0]     op;
		logic [DATA_WIDTH-1:0] word;
		logic [ADDR_W-1:0]     idx;
	} list_op_t;

	// one reply word as the block should return it
	typedef struct packed {
		status_t               status;
		logic [DATA_WIDTH-1:0] data;
		logic                  moved;
		logic [CNT_W-1:0]      count;
		logic [ADDR_W-1:0]     cursor;
	} list_reply_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_ready;
	logic [MODE_W-1:0]     mode       = '0;
	logic [DATA_WIDTH-1:0] data_in    = '0;
	logic [ADDR_W-1:0]     position   = '0;
	logic                  out_valid;
	logic                  out_ready  = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [DATA_WIDTH-1:0] data_out;
	logic                  moved;
	logic [CNT_W-1:0]      count;
	logic [ADDR_W-1:0]     cursor_pos;

	// stimulus waiting to be driven, replies waiting to arrive
	list_op_t    pending_words[$];
	list_reply_t expected_words[$];

	// shadow of the list as the block should hold it
	logic [DATA_WIDTH-1:0] shadow_store [DEPTH];
	int unsigned           shadow_len = 0;
	int unsigned           shadow_cur = 0;

	// list length as seen by the stimulus generator, used to aim indexes
	int unsigned gen_len     = 0;
	int unsigned items_total = 0;
	int unsigned items_taken = 0;

	int unsigned tx_wait = 0;
	int unsigned tx_calm = 0;
	int unsigned rx_wait = 0;
	int unsigned rx_calm = 0;
	int unsigned reports = 0;
	bit          failed  = 1'b0;

	cursor_array_list u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.data_in    (data_in),
		.position   (position),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.data_out   (data_out),
		.moved      (moved),
		.count      (count),
		.cursor_pos (cursor_pos)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// apply one operation to the shadow list and return the reply it should give
	function automatic list_reply_t apply_list_op(logic [MODE_W-1:0] op,
		logic [DATA_WIDTH-1:0] word, logic [ADDR_W-1:0] idx);
		list_reply_t r;
		int unsigned slot;
		int unsigned k;
		r.status = ST_OK;
		r.data   = '0;
		r.moved  = 1'b0;
		case (op)
			MODE_INS_BEFORE, MODE_INS_AFTER: begin
				if (shadow_len >= DEPTH) begin
					r.status = ST_FULL;
				end else if (shadow_len == 0) begin
					shadow_store[0] = word;
					shadow_cur = 0;
					shadow_len = 1;
				end else begin
					// open a slot at the cursor (before) or just above it (after)
					slot = (op == MODE_INS_BEFORE) ? shadow_cur : shadow_cur + 1;
					for (k = shadow_len; k > slot; k--)
						shadow_store[k] = shadow_store[k - 1];
					shadow_store[slot] = word;
					shadow_len++;
					// cursor follows its element up when inserting before it
					if (op == MODE_INS_BEFORE)
						shadow_cur++;
				end
			end
			MODE_DELETE: begin
				if (shadow_len == 0) begin
					r.status = ST_EMPTY;
				end else begin
					for (k = shadow_cur; k + 1 < shadow_len; k++)
						shadow_store[k] = shadow_store[k + 1];
					shadow_len--;
					// cursor steps back if it fell off the end
					if (shadow_len == 0)
						shadow_cur = 0;
					else if (shadow_cur == shadow_len)
						shadow_cur--;
				end
			end
			MODE_PREV: begin
				if (shadow_len == 0) begin
					r.status = ST_EMPTY;
				end else if (shadow_cur > 0) begin
					shadow_cur--;
					r.moved = 1'b1;
				end
			end
			MODE_NEXT: begin
				if (shadow_len == 0) begin
					r.status = ST_EMPTY;
				end else if (shadow_cur + 1 < shadow_len) begin
					shadow_cur++;
					r.moved = 1'b1;
				end
			end
			MODE_START: begin
				if (shadow_len == 0)
					r.status = ST_EMPTY;
				else
					shadow_cur = 0;
			end
			MODE_END: begin
				if (shadow_len == 0)
					r.status = ST_EMPTY;
				else
					shadow_cur = shadow_len - 1;
			end
			MODE_RD_CUR: begin
				if (shadow_len == 0)
					r.status = ST_EMPTY;
				else
					r.data = shadow_store[shadow_cur];
			end
			MODE_RD_IDX: begin
				if (idx >= shadow_len)
					r.status = ST_RANGE;
				else
					r.data = shadow_store[idx];
			end
			MODE_WR_IDX: begin
				if (idx >= shadow_len)
					r.status = ST_RANGE;
				else
					shadow_store[idx] = word;
			end
			default: begin
				// spare codes leave everything alone
			end
		endcase
		r.count  = CNT_W'(shadow_len);
		r.cursor = (shadow_len == 0) ? '0 : ADDR_W'(shadow_cur);
		return r;
	endfunction

	// per-word idle draw, with occasional calm stretches of no idling at all
	function automatic int unsigned pick_gap(inout int unsigned calm_left);
		if (calm_left != 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 6);
	endfunction

	// queue a word and track the list length it leaves behind
	task automatic push_op(logic [MODE_W-1:0] op, logic [DATA_WIDTH-1:0] word,
		logic [ADDR_W-1:0] idx);
		list_op_t item;
		item.op   = op;
		item.word = word;
		item.idx  = idx;
		pending_words.push_back(item);
		items_total++;
		if ((op == MODE_INS_BEFORE || op == MODE_INS_AFTER) && gen_len < DEPTH)
			gen_len++;
		else if (op == MODE_DELETE && gen_len != 0)
			gen_len--;
	endtask

	task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
		failed = 1'b1;
		if (reports < MAX_REPORTS) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
			reports++;
		end
	endtask

	// driver: presents queued words, predicts each reply as its word is taken
	always @(posedge clk or negedge arst_n) begin : tx_side
		list_op_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_words.push_back(apply_list_op(mode, data_in, position));
				items_taken++;
			end
			// the slot is free once the current word has gone or none is shown
			if (!in_valid || in_ready) begin
				if (tx_wait != 0) begin
					in_valid <= 1'b0;
					tx_wait--;
				end else if (pending_words.size() != 0) begin
					nxt = pending_words.pop_front();
					mode     <= nxt.op;
					data_in  <= nxt.word;
					position <= nxt.idx;
					in_valid <= 1'b1;
					tx_wait   = pick_gap(tx_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each reply word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : rx_side
		list_reply_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					failed = 1'b1;
					if (reports < MAX_REPORTS) begin
						$display("%0t: reply word with none expected, expected nothing, got status %0d count %0d",
							$time, status, count);
						reports++;
					end
				end else begin
					want = expected_words.pop_front();
					if (status !== want.status)
						note_mismatch("status", want.status, status);
					if (data_out !== want.data)
						note_mismatch("data_out", want.data, data_out);
					if (moved !== want.moved)
						note_mismatch("moved", want.moved, moved);
					if (count !== want.count)
						note_mismatch("count", want.count, count);
					if (cursor_pos !== want.cursor)
						note_mismatch("cursor_pos", want.cursor, cursor_pos);
				end
				rx_wait = pick_gap(rx_calm);
			end
			// stall after each taken word for the drawn number of cycles
			if (rx_wait != 0) begin
				out_ready <= 1'b0;
				rx_wait--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog: give up when nothing moves on either side for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("cursor_array_list test failed");
		$finish;
	end

	initial begin : stimulus
		int unsigned           n;
		int unsigned           r;
		int unsigned           target;
		int unsigned           ins_cut;
		int unsigned           del_cut;
		logic [DATA_WIDTH-1:0] word;
		logic [ADDR_W-1:0]     idx;

		// directed: every operation but insert on an empty list first
		push_op(MODE_DELETE, '1, '0);
		push_op(MODE_PREV, '0, '0);
		push_op(MODE_NEXT, '0, '0);
		push_op(MODE_START, '0, '0);
		push_op(MODE_END, '0, '0);
		push_op(MODE_RD_CUR, '0, '0);
		push_op(MODE_RD_IDX, '0, '0);
		push_op(MODE_WR_IDX, '1, '1);
		// first insert lands at index 0, insert before moves the cursor up
		push_op(MODE_INS_BEFORE, '1, '0);
		push_op(MODE_INS_BEFORE, '0, '1);
		push_op(MODE_INS_AFTER, 64'h8000_0000_0000_0001, '0);
		// moves, including the ones stuck at either end
		push_op(MODE_PREV, '0, '0);
		push_op(MODE_PREV, '0, '0);
		push_op(MODE_END, '0, '0);
		push_op(MODE_NEXT, '0, '0);
		push_op(MODE_START, '0, '0);
		push_op(MODE_NEXT, '0, '0);
		// reads in and out of range, and a write in range
		push_op(MODE_RD_CUR, '0, '0);
		push_op(MODE_RD_IDX, '0, 10'd2);
		push_op(MODE_WR_IDX, 64'haaaa_5555_aaaa_5555, '0);
		push_op(MODE_RD_IDX, '0, 10'd3);
		// delete at the last element steps back, then delete at the first
		push_op(MODE_END, '0, '0);
		push_op(MODE_DELETE, '0, '0);
		push_op(MODE_START, '0, '0);
		push_op(MODE_DELETE, '0, '0);
		push_op(MODE_SPARE_LO, '1, '1);

		// random: list length wanders around a moving target, mostly short
		target = 8;
		for (n = 0; n < RANDOM_OPS; n++) begin
			if (n % 60 == 0)
				target = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
					: $urandom_range(0, 40);
			r    = $urandom_range(0, 99);
			word = {$urandom, $urandom};
			if (gen_len != 0 && $urandom_range(0, 6) != 0)
				idx = ADDR_W'($urandom_range(0, gen_len - 1));
			else
				idx = ADDR_W'($urandom_range(0, DEPTH - 1));
			ins_cut = (gen_len < target) ? 45 : 20;
			del_cut = ins_cut + ((gen_len > target) ? 30 : 8);
			if (r < 2) begin
				push_op(MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)), word, idx);
			end else if (r < ins_cut) begin
				push_op($urandom_range(0, 1) ? MODE_INS_AFTER : MODE_INS_BEFORE, word, idx);
			end else if (r < del_cut) begin
				push_op(MODE_DELETE, word, idx);
			end else begin
				case (r % 8)
					0: push_op(MODE_PREV, word, idx);
					1: push_op(MODE_NEXT, word, idx);
					2: push_op(MODE_START, word, idx);
					3: push_op(MODE_END, word, idx);
					4: push_op(MODE_RD_CUR, word, idx);
					5: push_op(MODE_WR_IDX, word, idx);
					default: push_op(MODE_RD_IDX, word, idx);
				endcase
			end
		end

		// hold reset, then release it on a falling edge, away from the rising edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (items_taken < items_total)
			@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		// let any stray reply word show up
		repeat (DRAIN_TAIL) @(posedge clk);

		if (!failed)
			$display("cursor_array_list test passed");
		else
			$display("cursor_array_list test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
design/cal_pkg.sv
design/cal_ram.sv
design/cursor_array_list.sv
test/cursor_array_list_test.sv
